// File: hdl/dcms_pkg.sv
// Package for the DC motor simulation step: widths, register indexes,
// sequencer states and the truncating power-of-two divide helper.
// No dependencies.
package dcms_pkg;

   localparam int FIXED_SCALE_DEF = 1024;
   localparam int DATA_W          = 32;
   localparam int CMD_W           = 11;
   localparam int SMALL_W         = 10;
   localparam int COEF_W          = 16;
   localparam int CSR_ADDR_W      = 3;
   localparam int QUO_W           = 21;
   localparam logic [SMALL_W-1:0] PWM_FULL = 10'd1023;

   localparam logic [CSR_ADDR_W-1:0] REG_DEAD_ZONE  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FRICTION   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_BEMF_GAIN  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_POS_VEL    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_VEL_VEL    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_POS_DRIVE  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_VEL_DRIVE  = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMF,
      ST_BEMF,
      ST_VV,
      ST_VD,
      ST_PV,
      ST_PD,
      ST_FINISH
   } state_type;

   // signed divide by 2**sh, truncating toward zero
   function automatic logic signed [DATA_W-1:0] sdiv_pow2(
      input logic signed [DATA_W-1:0] a,
      input int unsigned              sh
   );
      logic signed [DATA_W-1:0] bias;
      bias = a[DATA_W-1] ? DATA_W'((64'd1 << sh) - 64'd1) : '0;
      return (a + bias) >>> sh;
   endfunction

endpackage

// File: hdl/dc_motor_sim_step_top.sv
// DC servo motor simulation step. Each req_ transfer carries one signed PWM
// command; the block rescales it past the dead zone (serial divider over 21
// quotient bits; skipped for a zero command or a full dead zone), adds the
// back-EMF term, subtracts Coulomb friction and updates velocity and position
// through the discrete state-space model, with sticking when the velocity
// would flip sign under no net drive. All products go through one shared
// bit-serial multiplier, six in a step (four when the motor sticks); the next
// command can be taken from the cycle in which rsp_tvalid rises, once the
// output register is free. One item is in flight at a time; the result sits
// in an output register so the next command can be taken while it waits.
// FIXED_SCALE must be a power of two; its divides are rounding-toward-zero
// shifts. The user must write registers through csr_ only while idle; the
// block itself does not enforce this.
// Depends on dcms_pkg, dcms_mul, dcms_div.
module dc_motor_sim_step_top import dcms_pkg::*; #(
   parameter int FIXED_SCALE = FIXED_SCALE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // command stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [10:0] pwm_command
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // [31:0] position, [63:32] velocity
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [COEF_W-1:0]     csr_wdata
);
   localparam int unsigned SH = $clog2(FIXED_SCALE);

   // configuration
   logic [SMALL_W-1:0] dz_ff, fr_ff;
   logic [COEF_W-1:0]  emf_ff, cpv_ff, cvv_ff, cpd_ff, cvd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff  <= '0;
         fr_ff  <= '0;
         emf_ff <= '0;
         cpv_ff <= 16'd625;
         cvv_ff <= 16'd1011;
         cpd_ff <= 16'd16;
         cvd_ff <= 16'd54;
      end else if (csr_we) begin
         case (csr_addr)
            REG_DEAD_ZONE: dz_ff  <= csr_wdata[SMALL_W-1:0];
            REG_FRICTION:  fr_ff  <= csr_wdata[SMALL_W-1:0];
            REG_BEMF_GAIN: emf_ff <= csr_wdata;
            REG_POS_VEL:   cpv_ff <= csr_wdata;
            REG_VEL_VEL:   cvv_ff <= csr_wdata;
            REG_POS_DRIVE: cpd_ff <= csr_wdata;
            REG_VEL_DRIVE: cvd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state and working registers
   state_type state_ff, state_in;
   logic signed [DATA_W-1:0] pos_ff, pos_in, vel_ff, vel_in;
   logic signed [DATA_W-1:0] drive_ff, drive_in, fric_ff, fric_in;
   logic signed [DATA_W-1:0] part_ff, part_in, nv_ff, nv_in;
   logic [QUO_W-1:0]         absd_ff, absd_in;
   logic                     neg_ff, neg_in;
   logic                     ov_ff, ov_in;
   logic [63:0]              out_ff, out_in;

   logic              mul_start, mul_done, div_start, div_done;
   logic [DATA_W-1:0] mul_a, mul_b, mul_p;
   logic [QUO_W-1:0]  div_num, div_q;

   dcms_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .done (mul_done), .p (mul_p)
   );

   dcms_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div_num), .den (PWM_FULL - dz_ff), .done (div_done), .quo (div_q)
   );

   // command front end: magnitude past the dead zone
   logic                accept, rsp_free, zero_path, stick;
   logic signed [CMD_W-1:0] cmd;
   logic [CMD_W-1:0]    mag, rest;
   logic signed [DATA_W-1:0] q_div1, q_div2, drive2, fric2, newvel, vel_sgn_fr;

   assign cmd       = req_tdata[CMD_W-1:0];
   assign mag       = cmd[CMD_W-1] ? CMD_W'(-cmd) : CMD_W'(cmd);
   assign rest      = (mag > {1'b0, dz_ff}) ? mag - {1'b0, dz_ff} : '0;
   assign div_num   = (QUO_W'(rest) << SMALL_W) - QUO_W'(rest);   // rest * 1023
   assign zero_path = (cmd == '0) || (dz_ff == PWM_FULL);
   assign accept    = req_tvalid && req_tready;
   assign rsp_free  = !ov_ff || rsp_tready;

   assign q_div1 = sdiv_pow2(mul_p, SH);
   assign q_div2 = sdiv_pow2(mul_p, 2 * SH);
   assign drive2 = drive_ff + q_div2;
   // friction opposes the sign of velocity; none at rest
   assign vel_sgn_fr = (vel_ff == '0) ? '0 :
                       vel_ff[DATA_W-1] ? -DATA_W'(fr_ff) : DATA_W'(fr_ff);
   assign fric2  = drive2 - vel_sgn_fr;
   assign newvel = part_ff + mul_p;
   assign stick  = ((drive_ff == '0) || (drive_ff[DATA_W-1] != fric_ff[DATA_W-1]))
                   && (newvel[DATA_W-1] != vel_ff[DATA_W-1]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = zero_path ? ST_EMF : ST_DIV;
         ST_DIV:    if (div_done) state_in = ST_EMF;
         ST_EMF:    if (mul_done) state_in = ST_BEMF;
         ST_BEMF:   if (mul_done) state_in = ST_VV;
         ST_VV:     if (mul_done) state_in = ST_VD;
         ST_VD:     if (mul_done) state_in = stick ? ST_FINISH : ST_PV;
         ST_PV:     if (mul_done) state_in = ST_PD;
         ST_PD:     if (mul_done) state_in = ST_FINISH;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // unit control
   always_comb begin
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_a     = DATA_W'(signed'(emf_ff));
      mul_b     = vel_ff;
      case (state_ff)
         ST_IDLE: begin
            div_start = accept && !zero_path;
            mul_start = accept && zero_path;
         end
         ST_DIV:  mul_start = div_done;
         ST_EMF: begin
            mul_start = mul_done;
            mul_a     = q_div1;
            mul_b     = DATA_W'(absd_ff);
         end
         ST_BEMF: begin
            mul_start = mul_done;
            mul_a     = DATA_W'(cvv_ff);
         end
         ST_VV: begin
            mul_start = mul_done;
            mul_a     = DATA_W'(cvd_ff);
            mul_b     = fric_ff;
         end
         ST_VD: begin
            mul_start = mul_done && !stick;
            mul_a     = DATA_W'(cpv_ff);
         end
         ST_PV: begin
            mul_start = mul_done;
            mul_a     = DATA_W'(cpd_ff);
            mul_b     = fric_ff;
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      pos_in   = pos_ff;
      vel_in   = vel_ff;
      drive_in = drive_ff;
      fric_in  = fric_ff;
      part_in  = part_ff;
      nv_in    = nv_ff;
      absd_in  = absd_ff;
      neg_in   = neg_ff;
      ov_in    = ov_ff;
      out_in   = out_ff;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         ST_IDLE: if (accept) begin
            neg_in   = cmd[CMD_W-1];
            drive_in = '0;
            absd_in  = '0;
         end
         ST_DIV: if (div_done) begin
            absd_in  = div_q;
            drive_in = neg_ff ? -DATA_W'(div_q) : DATA_W'(div_q);
         end
         ST_BEMF: if (mul_done) begin
            drive_in = drive2;
            fric_in  = fric2;
         end
         ST_VV: if (mul_done) part_in = q_div1;
         ST_VD: if (mul_done) begin
            if (stick) vel_in = '0;
            else nv_in = newvel;
         end
         ST_PV: if (mul_done) part_in = q_div1;
         ST_PD: if (mul_done) begin
            pos_in = pos_ff + sdiv_pow2(part_ff + mul_p, SH);
            vel_in = nv_ff;
         end
         ST_FINISH: if (rsp_free) begin
            ov_in  = 1'b1;
            out_in = {vel_ff, pos_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         vel_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         vel_ff   <= vel_in;
         ov_ff    <= ov_in;
      end
      drive_ff <= drive_in;
      fric_ff  <= fric_in;
      part_ff  <= part_in;
      nv_ff    <= nv_in;
      absd_ff  <= absd_in;
      neg_ff   <= neg_in;
      out_ff   <= out_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   a_mul_in_step : assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff != ST_IDLE && state_ff != ST_DIV && state_ff != ST_FINISH)
      else $error("multiplier result outside a multiply step");
   a_div_in_step : assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV) else $error("divider result outside rescale");
   a_result_load : assert property (@(posedge clock) disable iff (reset)
      $rose(ov_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result loaded outside finish");
   a_stick_zero : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_VD && mul_done && stick |=> vel_ff == '0)
      else $error("sticking did not clear velocity");
endmodule

// File: hdl/dcms_mul.sv
// Bit-serial 32x32 multiplier, low word of the product, one bit per cycle.
// Depends on dcms_pkg.
module dcms_mul import dcms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] a,
   input  logic [DATA_W-1:0] b,
   output logic              done,
   output logic [DATA_W-1:0] p
);
   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] mc_ff, mc_in;
   logic [DATA_W-1:0] mp_ff, mp_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DATA_W - 1);
         acc_in  = '0;
         mc_in   = a;
         mp_in   = b;
      end else if (busy_ff) begin
         acc_in = acc_ff + (mp_ff[0] ? mc_ff : '0);
         mc_in  = mc_ff << 1;
         mp_in  = mp_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign done = done_ff;
   assign p    = acc_ff;

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("multiplier restarted while busy");
   a_done_after : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while still busy");
   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held longer than one cycle");
endmodule

// File: hdl/dcms_div.sv
// Restoring serial divider for the dead-zone rescale, one quotient bit per cycle.
// Depends on dcms_pkg.
module dcms_div import dcms_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [QUO_W-1:0]   num,
   input  logic [SMALL_W-1:0] den,
   output logic               done,
   output logic [QUO_W-1:0]   quo
);
   localparam int CNT_W = $clog2(QUO_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SMALL_W:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]   q_ff, q_in;
   logic [SMALL_W-1:0] den_ff, den_in;
   logic [SMALL_W+1:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      trial   = {rem_ff, q_ff[QUO_W-1]} - {2'b00, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUO_W - 1);
         rem_in  = '0;
         q_in    = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (!trial[SMALL_W+1]) begin
            rem_in = trial[SMALL_W:0];
            q_in   = {q_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[SMALL_W-1:0], q_ff[QUO_W-1]};
            q_in   = {q_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

   a_rem_lt_den : assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |=> rem_ff < {1'b0, den_ff})
      else $error("partial remainder not below divisor");
   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held longer than one cycle");
endmodule
